>>> hw/rtl/flc_pkg.sv
// shared types, constants and helpers for the fir linear convolution block
package flc_pkg;

	// defaults for the top-level parameters
	localparam int MAX_TAPS_DEF    = 32;
	localparam int SAMPLE_BITS_DEF = 16;

	// fixed field widths
	localparam int TAP_INDEX_BITS = 5;
	localparam int TAP_COUNT_BITS = 6;
	localparam int RESULT_BITS    = 36;
	localparam int OUT_DATA_BITS  = 40;

	// configuration port
	localparam int CFG_ADDR_BITS = 1;
	localparam int CFG_DATA_BITS = TAP_COUNT_BITS;
	localparam logic [CFG_ADDR_BITS-1:0] REG_TAP_COUNT  = 1'b0;
	localparam logic [CFG_ADDR_BITS-1:0] REG_VALID_ONLY = 1'b1;

	// command queue between front and back
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic {
		CMD_LOAD   = 1'b0,
		CMD_SAMPLE = 1'b1
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t                 kind;
		logic                      tap_ok;
		logic [TAP_INDEX_BITS-1:0] tap_index;
		logic                      last;
	} cmd_ctrl_t;

	typedef enum logic {
		BK_RUN   = 1'b0,
		BK_FLUSH = 1'b1
	} back_state_t;

	typedef struct packed {
		logic flushing;
		logic issue;
		logic emit;
		logic emit_last;
	} bk_status_t;

	// input tdata width: tap index and sample, padded to whole bytes
	function automatic int in_data_bits(int sample_bits);
		return ((TAP_INDEX_BITS + sample_bits + 7) / 8) * 8;
	endfunction

endpackage

>>> hw/rtl/flc_queue.sv
// small register fifo carrying decoded requests from front to back
module flc_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             not_empty,
	output logic             full
);
	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	logic [WIDTH-1:0]    mem_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;

	assign pop_data  = mem_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign full      = (count_q == CNT_BITS'(DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

>>> hw/rtl/flc_front.sv
// input side: takes requests, classifies them and queues them for the back end
module flc_front #(
	parameter int MAX_TAPS    = flc_pkg::MAX_TAPS_DEF,
	parameter int SAMPLE_BITS = flc_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          s_tvalid,
	output logic                                          s_tready,
	input  logic [flc_pkg::in_data_bits(SAMPLE_BITS)-1:0] s_tdata,
	input  logic                                          s_tuser,
	input  logic                                          s_tlast,
	output logic                                          cmd_valid,
	input  logic                                          cmd_pop,
	output flc_pkg::cmd_ctrl_t                            cmd_ctrl,
	output logic signed [SAMPLE_BITS-1:0]                 cmd_value
);
	import flc_pkg::*;

	localparam int WORD_BITS = $bits(cmd_ctrl_t) + SAMPLE_BITS;

	cmd_ctrl_t            in_ctrl;
	logic                 push;
	logic                 full;
	logic [WORD_BITS-1:0] push_word;
	logic [WORD_BITS-1:0] pop_word;

	// classify: request kind, index range check
	always_comb begin
		in_ctrl.kind      = cmd_kind_t'(s_tuser);
		in_ctrl.tap_index = s_tdata[TAP_INDEX_BITS-1:0];
		in_ctrl.tap_ok    = (int'(s_tdata[TAP_INDEX_BITS-1:0]) < MAX_TAPS);
		in_ctrl.last      = s_tlast;
	end

	assign s_tready  = !full;
	assign push      = s_tvalid && !full;
	assign push_word = {in_ctrl, s_tdata[TAP_INDEX_BITS +: SAMPLE_BITS]};

	flc_queue #(
		.WIDTH(WORD_BITS),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_word),
		.pop      (cmd_pop),
		.pop_data (pop_word),
		.not_empty(cmd_valid),
		.full     (full)
	);

	assign cmd_ctrl  = cmd_ctrl_t'(pop_word[WORD_BITS-1:SAMPLE_BITS]);
	assign cmd_value = $signed(pop_word[SAMPLE_BITS-1:0]);
endmodule

>>> hw/rtl/flc_dot.sv
// parallel tap multipliers followed by a registered adder tree
module flc_dot #(
	parameter int MAX_TAPS    = flc_pkg::MAX_TAPS_DEF,
	parameter int SAMPLE_BITS = flc_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    en,
	input  logic                                    in_valid,
	input  logic                                    in_last,
	input  logic [$clog2(MAX_TAPS+1)-1:0]           taps_used,
	input  logic signed [SAMPLE_BITS-1:0]           taps [MAX_TAPS],
	input  logic signed [SAMPLE_BITS-1:0]           line [MAX_TAPS],
	output logic                                    res_valid,
	output logic                                    res_last,
	output logic signed [flc_pkg::RESULT_BITS-1:0]  res_value
);
	import flc_pkg::*;

	localparam int LEVELS    = $clog2(MAX_TAPS);
	localparam int TREE_N    = 1 << LEVELS;
	localparam int NODES     = 2 * TREE_N - 1;
	localparam int PROD_BITS = 2 * SAMPLE_BITS;

	// heap order: node i has children 2i+1 and 2i+2, leaves hold the products
	logic signed [RESULT_BITS-1:0] sum_s [NODES];
	logic [LEVELS:0]               vld_s;
	logic [LEVELS:0]               lst_s;

	for (genvar k = 0; k < TREE_N; k++) begin : g_lane
		if (k < MAX_TAPS) begin : g_mul
			logic signed [PROD_BITS-1:0]   prod;
			logic signed [RESULT_BITS-1:0] leaf;
			logic                          in_use;

			assign prod   = taps[k] * line[k];
			assign leaf   = RESULT_BITS'(prod);
			assign in_use = (k < int'(taps_used));

			always_ff @(posedge clk) begin
				if (en) begin
					sum_s[TREE_N-1+k] <= in_use ? leaf : '0;
				end
			end
		end else begin : g_pad
			always_ff @(posedge clk) begin
				if (en) begin
					sum_s[TREE_N-1+k] <= '0;
				end
			end
		end
	end

	for (genvar i = 0; i < TREE_N - 1; i++) begin : g_node
		always_ff @(posedge clk) begin
			if (en) begin
				sum_s[i] <= sum_s[2*i+1] + sum_s[2*i+2];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LEVELS-1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lst_s <= {lst_s[LEVELS-1:0], in_last};
		end
	end

	assign res_valid = vld_s[LEVELS];
	assign res_last  = lst_s[LEVELS];
	assign res_value = sum_s[0];
endmodule

>>> hw/rtl/flc_back.sv
// execution side: tap store, delay line, tail flush sequencer and output register
module flc_back #(
	parameter int MAX_TAPS    = flc_pkg::MAX_TAPS_DEF,
	parameter int SAMPLE_BITS = flc_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic [flc_pkg::TAP_COUNT_BITS-1:0]    tap_count,
	input  logic                                  valid_only,
	input  logic                                  cmd_valid,
	output logic                                  cmd_pop,
	input  flc_pkg::cmd_ctrl_t                    cmd_ctrl,
	input  logic signed [SAMPLE_BITS-1:0]         cmd_value,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [flc_pkg::OUT_DATA_BITS-1:0]     m_tdata,
	output logic                                  m_tlast,
	output flc_pkg::bk_status_t                   status
);
	import flc_pkg::*;

	localparam int SEEN_BITS = $clog2(MAX_TAPS + 1);

	back_state_t                    state_q;
	back_state_t                    state_d;
	logic [SEEN_BITS-1:0]           m_use;
	logic [SEEN_BITS-1:0]           seen_q;
	logic [SEEN_BITS-1:0]           seen_inc;
	logic [SEEN_BITS-1:0]           rem_q;
	logic signed [SAMPLE_BITS-1:0]  taps_q [MAX_TAPS];
	logic signed [SAMPLE_BITS-1:0]  line_q [MAX_TAPS];
	logic signed [SAMPLE_BITS-1:0]  line_shift [MAX_TAPS];
	logic signed [SAMPLE_BITS-1:0]  shift_in;
	logic                           en;
	logic                           issue;
	logic                           emit;
	logic                           emit_last;
	logic                           clear_line;
	logic                           start_flush;
	logic                           res_valid;
	logic                           res_last;
	logic signed [RESULT_BITS-1:0]  res_value;
	logic                           out_valid_q;
	logic                           out_last_q;
	logic signed [RESULT_BITS-1:0]  out_value_q;

	// taps in use, clamped to 1..MAX_TAPS
	always_comb begin
		if (tap_count == '0) begin
			m_use = SEEN_BITS'(1);
		end else if (int'(tap_count) > MAX_TAPS) begin
			m_use = SEEN_BITS'(MAX_TAPS);
		end else begin
			m_use = SEEN_BITS'(tap_count);
		end
	end

	assign seen_inc = (int'(seen_q) < MAX_TAPS) ? seen_q + 1'b1 : seen_q;
	assign en       = !out_valid_q || m_tready;

	// sequencer outputs
	always_comb begin
		cmd_pop     = 1'b0;
		issue       = 1'b0;
		emit        = 1'b0;
		emit_last   = 1'b0;
		clear_line  = 1'b0;
		start_flush = 1'b0;
		shift_in    = cmd_value;
		case (state_q)
			BK_RUN: begin
				cmd_pop = en && cmd_valid;
				if (cmd_pop && cmd_ctrl.kind == CMD_SAMPLE) begin
					issue = 1'b1;
					if (valid_only) begin
						emit       = (seen_inc >= m_use);
						emit_last  = cmd_ctrl.last;
						clear_line = cmd_ctrl.last;
					end else begin
						emit        = 1'b1;
						emit_last   = cmd_ctrl.last && (m_use == SEEN_BITS'(1));
						clear_line  = cmd_ctrl.last && (m_use == SEEN_BITS'(1));
						start_flush = cmd_ctrl.last && (m_use != SEEN_BITS'(1));
					end
				end
			end
			BK_FLUSH: begin
				shift_in   = '0;
				issue      = en;
				emit       = en;
				emit_last  = (rem_q == SEEN_BITS'(1));
				clear_line = en && (rem_q == SEEN_BITS'(1));
			end
			default: begin
				shift_in = cmd_value;
			end
		endcase
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_RUN: begin
				if (start_flush) begin
					state_d = BK_FLUSH;
				end
			end
			BK_FLUSH: begin
				if (issue && rem_q == SEEN_BITS'(1)) begin
					state_d = BK_RUN;
				end
			end
			default: begin
				state_d = BK_RUN;
			end
		endcase
	end

	always_comb begin
		line_shift[0] = shift_in;
		for (int k = 1; k < MAX_TAPS; k++) begin
			line_shift[k] = line_q[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_RUN;
			rem_q   <= '0;
			seen_q  <= '0;
		end else begin
			state_q <= state_d;
			if (start_flush) begin
				rem_q <= m_use - 1'b1;
			end else if (state_q == BK_FLUSH && issue) begin
				rem_q <= rem_q - 1'b1;
			end
			if (issue) begin
				if (clear_line) begin
					seen_q <= '0;
				end else if (state_q == BK_RUN) begin
					seen_q <= seen_inc;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_TAPS; k++) begin
				line_q[k] <= '0;
			end
		end else if (issue) begin
			for (int k = 0; k < MAX_TAPS; k++) begin
				line_q[k] <= clear_line ? '0 : line_shift[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_TAPS; k++) begin
				taps_q[k] <= '0;
			end
		end else if (cmd_pop && cmd_ctrl.kind == CMD_LOAD && cmd_ctrl.tap_ok) begin
			for (int k = 0; k < MAX_TAPS; k++) begin
				if (int'(cmd_ctrl.tap_index) == k) begin
					taps_q[k] <= cmd_value;
				end
			end
		end
	end

	flc_dot #(
		.MAX_TAPS   (MAX_TAPS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_dot (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (issue && emit),
		.in_last  (emit_last),
		.taps_used(m_use),
		.taps     (taps_q),
		.line     (line_shift),
		.res_valid(res_valid),
		.res_last (res_last),
		.res_value(res_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_value_q <= res_value;
			out_last_q  <= res_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {{(OUT_DATA_BITS - RESULT_BITS){1'b0}}, out_value_q};

	always_comb begin
		status.flushing  = (state_q == BK_FLUSH);
		status.issue     = issue;
		status.emit      = emit;
		status.emit_last = emit_last;
	end
endmodule

>>> hw/rtl/fir_linear_convolution.sv
// top level of the streaming fir linear convolution block
// Streaming direct-form FIR: a load request (tuser 0) writes one Q1.15 coefficient
// into the tap store, a sample request (tuser 1) shifts a Q1.15 sample into the
// delay line and produces the 36-bit sum of tap_count (clamped to 1..MAX_TAPS)
// products, exact unless it reaches 2^35 and wraps. In full mode the sample marked
// tlast also flushes tap_count-1 tail outputs; in valid-only mode only fully
// overlapped outputs appear. After the final sample the delay line and sample
// count clear; coefficients are kept. Throughput is one request per cycle while
// the output side is ready and no tail is draining: a front end queues requests
// in a four-entry fifo, the back end issues one per cycle into MAX_TAPS parallel
// multipliers and a registered adder tree. A final sample in full mode holds the
// back end while the tail drains, and the input stalls once the fifo fills.
// Configure tap_count and valid_only only while no request is in flight.
module fir_linear_convolution #(
	parameter int MAX_TAPS    = flc_pkg::MAX_TAPS_DEF,
	parameter int SAMPLE_BITS = flc_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	// configuration writes
	input  logic                                          cfg_we,
	input  logic [flc_pkg::CFG_ADDR_BITS-1:0]             cfg_addr,
	input  logic [flc_pkg::CFG_DATA_BITS-1:0]             cfg_wdata,
	// request stream
	input  logic                                          s_tvalid,
	output logic                                          s_tready,
	// tap_index, value, zero padding
	input  logic [flc_pkg::in_data_bits(SAMPLE_BITS)-1:0] s_tdata,
	// req_type
	input  logic                                          s_tuser,
	input  logic                                          s_tlast,
	// result stream
	output logic                                          m_tvalid,
	input  logic                                          m_tready,
	// result_value, zero padding
	output logic [flc_pkg::OUT_DATA_BITS-1:0]             m_tdata,
	output logic                                          m_tlast
);
	import flc_pkg::*;

	logic [TAP_COUNT_BITS-1:0]     tap_count_q;
	logic                          valid_only_q;
	logic                          cmd_valid;
	logic                          cmd_pop;
	cmd_ctrl_t                     cmd_ctrl;
	logic signed [SAMPLE_BITS-1:0] cmd_value;
	bk_status_t                    bk_status;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q  <= TAP_COUNT_BITS'(1);
			valid_only_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_TAP_COUNT: begin
					tap_count_q <= cfg_wdata;
				end
				REG_VALID_ONLY: begin
					valid_only_q <= cfg_wdata[0];
				end
				default: begin
					valid_only_q <= valid_only_q;
				end
			endcase
		end
	end

	// front end: accept and classify requests
	flc_front #(
		.MAX_TAPS   (MAX_TAPS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.cmd_valid(cmd_valid),
		.cmd_pop  (cmd_pop),
		.cmd_ctrl (cmd_ctrl),
		.cmd_value(cmd_value)
	);

	// back end: taps, delay line, tail flush, dot product, output register
	flc_back #(
		.MAX_TAPS   (MAX_TAPS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tap_count (tap_count_q),
		.valid_only(valid_only_q),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd_ctrl  (cmd_ctrl),
		.cmd_value (cmd_value),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.status    (bk_status)
	);

	// never pop an empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid)
		else $error("request popped from empty queue");

	// no request leaves the queue while the tail drains
	a_no_pop_in_flush: assert property (@(posedge clk) disable iff (!arst_n)
		bk_status.flushing |-> !cmd_pop)
		else $error("request popped during tail flush");

	// every tail step produces a result
	a_flush_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(bk_status.flushing && bk_status.issue) |-> bk_status.emit)
		else $error("tail step without result");

	// the marked tail output ends the flush
	a_flush_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(bk_status.flushing && bk_status.issue && bk_status.emit_last) |=> !bk_status.flushing)
		else $error("flush continues after final output");
endmodule

>>> test/tb.sv
// self-checking testbench for the streaming fir linear convolution block
`timescale 1ns / 1ps

module tb;
	import flc_pkg::*;

	localparam int TAPS          = MAX_TAPS_DEF;
	localparam int IN_BITS       = in_data_bits(SAMPLE_BITS_DEF);
	localparam int SETTLE_CYCLES = 16;    // pipeline depth plus the request fifo, with margin
	localparam int RX_HOLD_LEN   = 300;   // long output stall used to back up the pipe
	localparam int STUCK_LIMIT   = 5000;  // cycles without any handshake before giving up

	// one expected output of the convolution
	typedef struct {
		logic signed [RESULT_BITS-1:0] sum;
		logic                          last;
	} conv_out_t;

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               cfg_we = 1'b0;
	logic [CFG_ADDR_BITS-1:0]           cfg_addr = '0;
	logic [CFG_DATA_BITS-1:0]           cfg_wdata = '0;
	logic                               s_tvalid = 1'b0;
	logic                               s_tready;
	logic [IN_BITS-1:0]                 s_tdata = '0;  // tap_index, value, zero padding
	logic                               s_tuser = 1'b0; // req_type
	logic                               s_tlast = 1'b0;
	logic                               m_tvalid;
	logic                               m_tready = 1'b0;
	logic [OUT_DATA_BITS-1:0]           m_tdata;       // result_value, zero padding
	logic                               m_tlast;

	// predictor state, mirrors what the block holds
	logic signed [SAMPLE_BITS_DEF-1:0]  coef [TAPS];
	logic signed [SAMPLE_BITS_DEF-1:0]  history [TAPS];
	int unsigned                        fill_count;
	logic [TAP_COUNT_BITS-1:0]          taps_reg;
	logic                               valid_only_reg;

	conv_out_t                          pending_sums [$];

	int                                 mismatches;
	int                                 requests_sent;
	int                                 results_checked;
	int                                 frames_run;
	int                                 stuck_cycles = 0;
	int                                 send_idle_pct;
	int                                 recv_idle_pct = 0;
	logic                               rx_holding = 1'b0;
	event                               rx_hold_ev;

	fir_linear_convolution dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------- predictor

	// tap count of zero acts as one, anything past the store size as the full store
	function automatic int taps_active();
		if (taps_reg == 0)
			return 1;
		if (taps_reg > TAPS)
			return TAPS;
		return int'(taps_reg);
	endfunction

	// exact dot product of the first m taps with the delay line, wrapped to the field
	function automatic logic signed [RESULT_BITS-1:0] tap_sum(input int m);
		longint acc;
		acc = 0;
		for (int k = 0; k < m; k++)
			acc += longint'(coef[k]) * longint'(history[k]);
		return acc[RESULT_BITS-1:0];
	endfunction

	function automatic void shift_history(input logic signed [SAMPLE_BITS_DEF-1:0] x);
		for (int i = TAPS - 1; i > 0; i--)
			history[i] = history[i-1];
		history[0] = x;
	endfunction

	function automatic void expect_sum(input int m, input logic last);
		conv_out_t e;
		e.sum  = tap_sum(m);
		e.last = last;
		pending_sums.push_back(e);
	endfunction

	// works out every output caused by one accepted request
	function automatic void predict_request(input cmd_kind_t kind, input logic [4:0] idx,
			input logic signed [SAMPLE_BITS_DEF-1:0] x, input logic fin);
		int m;
		m = taps_active();
		if (kind == CMD_LOAD) begin
			// coefficient write only, the last flag means nothing here
			coef[idx] = x;
			return;
		end
		shift_history(x);
		if (fill_count < TAPS)
			fill_count++;
		if (valid_only_reg) begin
			// only fully overlapped positions; a short signal gives nothing at all
			if (fill_count >= m)
				expect_sum(m, fin);
		end else begin
			expect_sum(m, fin && m == 1);
			if (fin) begin
				// tail: shift zeros through, last flag on the final one
				for (int i = 1; i < m; i++) begin
					shift_history('0);
					expect_sum(m, i == m - 1);
				end
			end
		end
		if (fin) begin
			foreach (history[i])
				history[i] = '0;
			fill_count = 0;
		end
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t ns: %s", $time, what);
		mismatches++;
	endtask

	// --------------------------------------------------------- monitor and check

	// everything sampled at the rising edge sees the values that edge captured
	always @(posedge clk) begin
		conv_out_t e;
		if (arst_n) begin
			if (cfg_we) begin
				if (cfg_addr == REG_TAP_COUNT)
					taps_reg = cfg_wdata;
				else if (cfg_addr == REG_VALID_ONLY)
					valid_only_reg = cfg_wdata[0];
			end
			if (s_tvalid && s_tready)
				predict_request(cmd_kind_t'(s_tuser), s_tdata[4:0], s_tdata[20:5], s_tlast);
			if (m_tvalid && m_tready) begin
				results_checked++;
				if (pending_sums.size() == 0) begin
					report_mismatch($sformatf("unexpected result %0d last %0b",
						$signed(m_tdata[RESULT_BITS-1:0]), m_tlast));
				end else begin
					e = pending_sums.pop_front();
					if (m_tdata[RESULT_BITS-1:0] !== e.sum)
						report_mismatch($sformatf("sum %0d, expected %0d",
							$signed(m_tdata[RESULT_BITS-1:0]), e.sum));
					if (m_tlast !== e.last)
						report_mismatch($sformatf("last %b, expected %b", m_tlast, e.last));
				end
			end
		end
	end

	// receiver: random stalls, or a long hold while a hold is running
	always @(posedge clk)
		m_tready <= !rx_holding && ($urandom_range(99) >= recv_idle_pct);

	// long hold on the output side, counted here so the sender keeps going meanwhile
	always @(rx_hold_ev) begin
		rx_holding <= 1'b1;
		repeat (RX_HOLD_LEN) @(posedge clk);
		rx_holding <= 1'b0;
	end

	// watchdog: ends the run if neither side moves for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("timeout: no handshake for %0d cycles", STUCK_LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// ---------------------------------------------------------- driving helpers

	// offers one request and returns at the edge that accepts it; valid stays high
	task automatic send_request(input cmd_kind_t kind, input logic [4:0] idx,
			input logic signed [SAMPLE_BITS_DEF-1:0] x, input logic fin);
		logic [IN_BITS-1:0] word;
		word       = '0;
		word[4:0]  = idx;
		word[20:5] = x;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tlast  <= fin;
		s_tdata  <= word;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		requests_sent++;
	endtask

	task automatic load_tap(input logic [4:0] idx, input logic signed [15:0] x);
		send_request(CMD_LOAD, idx, x, 1'b0);
	endtask

	task automatic send_sample(input logic signed [15:0] x, input logic fin);
		send_request(CMD_SAMPLE, 5'($urandom_range(31)), x, fin);
	endtask

	// stop offering, wait for every pending output, then let loads and
	// valid-mode samples that give nothing work through the pipe
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_sums.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] addr,
			input logic [CFG_DATA_BITS-1:0] data);
		cfg_we    <= 1'b1;
		cfg_addr  <= addr;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic [CFG_DATA_BITS-1:0] taps, input logic vmode);
		wait_idle();
		write_reg(REG_TAP_COUNT, taps);
		write_reg(REG_VALID_ONLY, {{(CFG_DATA_BITS-1){1'b0}}, vmode});
	endtask

	// random Q1.15 value leaning on the extremes
	function automatic logic signed [15:0] rand_value();
		case ($urandom_range(7))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'sh0000;
			3: return 16'shffff;
			default: return 16'($urandom_range(16'hffff));
		endcase
	endfunction

	// ----------------------------------------------------------------- tests

	// reset values: one tap, all coefficients zero, full mode
	task automatic test_reset_state();
		send_sample(16'sd1234, 1'b0);
		send_sample(-16'sd5, 1'b1);
	endtask

	// single tap with both sample extremes; the last flag on a load is ignored
	task automatic test_single_tap_extremes();
		load_tap(5'd0, 16'sh8000);
		send_request(CMD_LOAD, 5'd31, 16'sh7fff, 1'b1);
		send_sample(16'sh7fff, 1'b0);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'shffff, 1'b1);
	endtask

	// full convolution with a tail of tap_count-1 outputs
	task automatic test_full_tail();
		configure(6'd3, 1'b0);
		load_tap(5'd1, 16'sh7fff);
		load_tap(5'd2, 16'sd100);
		send_sample(16'sd300, 1'b0);
		send_sample(-16'sd7000, 1'b0);
		send_sample(16'sh7fff, 1'b0);
		send_sample(16'sh8000, 1'b1);
	endtask

	// valid mode: overlapped outputs only, then a signal shorter than the taps
	task automatic test_valid_mode();
		configure(6'd3, 1'b1);
		send_sample(16'sd11, 1'b0);
		send_sample(16'sd22, 1'b0);
		send_sample(-16'sd33, 1'b0);
		send_sample(16'sd44, 1'b1);
		send_sample(16'sd55, 1'b0);
		send_sample(16'sd66, 1'b1);
	endtask

	// tap count zero acts as one, a count above the store acts as the whole store
	task automatic test_count_limits();
		configure(6'd0, 1'b1);
		send_sample(16'sd9, 1'b0);
		send_sample(-16'sd9, 1'b1);
		configure(6'd63, 1'b0);
		send_sample(16'sh7fff, 1'b1);
	endtask

	// every product at +2^30 over all taps: the one sum that wraps the field
	task automatic test_sum_wrap();
		configure(6'd32, 1'b1);
		for (int i = 0; i < TAPS; i++)
			load_tap(i[4:0], 16'sh8000);
		for (int i = 0; i < TAPS; i++)
			send_sample(16'sh8000, i == TAPS - 1);
	endtask

	// output held off for a long stretch while samples keep coming, so the
	// pipe and the request fifo fill and the input stalls
	task automatic test_backpressure();
		configure(6'd4, 1'b0);
		-> rx_hold_ev;
		for (int i = 0; i < 12; i++)
			send_sample(rand_value(), i == 11);
		wait_idle();
	endtask

	// random signals: mostly well-formed frames with random content and settings,
	// stray loads mixed in; large tap counts kept rare
	task automatic run_random_frames(input int target);
		int items;
		int len;
		int pick;
		logic [CFG_DATA_BITS-1:0] taps;
		items = 0;
		while (items < target) begin
			if (frames_run == 0 || $urandom_range(1)) begin
				pick = $urandom_range(19);
				case (pick)
					0: taps = 6'd0;
					1: taps = 6'd63;
					2: taps = 6'd32;
					3, 4, 5: taps = 6'd1;
					default: taps = CFG_DATA_BITS'($urandom_range(2, 8));
				endcase
				configure(taps, 1'($urandom_range(1)));
			end
			repeat ($urandom_range(4)) begin
				send_request(CMD_LOAD, 5'($urandom_range(31)), rand_value(),
					1'($urandom_range(1)));
				items++;
			end
			len = $urandom_range(1, 12);
			for (int j = 0; j < len; j++) begin
				if ($urandom_range(7) == 0) begin
					load_tap(5'($urandom_range(31)), rand_value());
					items++;
				end
				send_sample(rand_value(), j == len - 1);
				items++;
			end
			frames_run++;
		end
	endtask

	// ----------------------------------------------------------------- sequence

	initial begin
		foreach (coef[i]) begin
			coef[i]    = '0;
			history[i] = '0;
		end
		fill_count     = 0;
		taps_reg       = 6'd1;
		valid_only_reg = 1'b0;
		mismatches     = 0;
		requests_sent  = 0;
		results_checked = 0;
		frames_run     = 0;
		send_idle_pct  = 30;
		recv_idle_pct  <= 48;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sender idles 30 of 100, receiver 48
		test_reset_state();
		test_single_tap_extremes();
		test_full_tail();
		test_valid_mode();
		test_count_limits();
		test_sum_wrap();
		test_backpressure();

		// swapped idling
		send_idle_pct = 48;
		recv_idle_pct <= 30;
		run_random_frames(6);

		// no idling on either side
		wait_idle();
		send_idle_pct = 0;
		recv_idle_pct <= 0;
		run_random_frames(6);

		wait_idle();
		if (pending_sums.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_sums.size()));

		$display("covered %0d requests over %0d random frames, %0d results checked",
			requests_sent, frames_run, results_checked);
		$display("tap counts 0 to 63, both modes, sum wrap, long output stall; %0d mismatches",
			mismatches);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

>>> files.f
hw/rtl/flc_pkg.sv
hw/rtl/flc_queue.sv
hw/rtl/flc_front.sv
hw/rtl/flc_dot.sv
hw/rtl/flc_back.sv
hw/rtl/fir_linear_convolution.sv
test/tb.sv
